// ===== design/ttl_aging_ring_buffer_defines.svh =====
// Assertion macros shared by the ring buffer checker.
// Needs clk and rst_n in scope where used.
`ifndef TTL_AGING_RING_BUFFER_DEFINES_SVH
`define TTL_AGING_RING_BUFFER_DEFINES_SVH

// implication into the following cycle
`define TARB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// implication in the same cycle
`define TARB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/tarb_pkg.sv =====
// Types and constants for the TTL aging ring buffer.
// No dependencies; used by the top level and its checker.
package tarb_pkg;

  localparam int          DEPTH_DEF    = 64;
  localparam logic [15:0] MAX_LIFE_RST = 16'd4096;
  localparam logic [5:0]  COUNT_MAX    = 6'd63;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] step_time;
  } in_req_t;

  typedef struct packed {
    logic [5:0] live_count;
    logic       is_empty;
    logic [5:0] expired_count;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } tarb_state_t;

endpackage

// ===== design/ttl_aging_ring_buffer.sv =====
// TTL aging ring buffer top level: point store, life store and walk sequencer.
// Depends on tarb_pkg.
//
// Points are added at the head with life max_life; a tick walks the live entries
// oldest to newest through one shared compare/subtract unit, expiring entries whose
// life is at or below the step and aging the rest. An add request and a tick on an
// empty buffer finish in the accept cycle. A tick over the live entries issues the first
// read of the life store in the accept cycle, walks the entries in turn (a single
// read and a single write port of the life store), then posts the result. The input
// is stalled while a tick walks or waits to post its result, or while the result
// register is full and stalled. The stores need no clearing after reset.
module ttl_aging_ring_buffer
  import tarb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_rsp_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = ((IW > 6) ? IW : 6) + 1;

  logic [15:0] life_mem [DEPTH];
  logic [31:0] pos_mem  [DEPTH];

  tarb_state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] exp_r, exp_nxt;
  logic          empty_r, empty_nxt;
  logic [15:0]   step_r, step_nxt;
  logic [15:0]   max_life_r;
  logic [15:0]   life_q_r;

  logic          out_valid_r;
  out_rsp_t      out_data_r;

  logic [IW-1:0] rd_addr;
  logic          we;
  logic          pos_we;
  logic [IW-1:0] waddr;
  logic [15:0]   wdata;
  logic          load_out;
  logic          out_free;
  logic          in_acc;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] span;
  logic [CW-1:0] live_w;
  logic [CW-1:0] exp_w;
  out_rsp_t      rsp;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    if (i == IW'(DEPTH - 1)) return '0;
    return i + 1'b1;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_inc   = wrap_inc(cur_r);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    exp_nxt   = exp_r;
    empty_nxt = empty_r;
    step_nxt  = step_r;
    rd_addr   = tail_r;
    we        = 1'b0;
    pos_we    = 1'b0;
    waddr     = head_r;
    wdata     = max_life_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          exp_nxt = '0;
          if (in_data.func == FUNC_ADD) begin
            we        = 1'b1;
            pos_we    = 1'b1;
            head_nxt  = wrap_inc(head_r);
            if (wrap_inc(head_r) == tail_r) tail_nxt = wrap_inc(tail_r);
            empty_nxt = 1'b0;
            load_out  = 1'b1;
          end else if (empty_r) begin
            load_out = 1'b1;
          end else begin
            step_nxt  = in_data.step_time;
            cur_nxt   = tail_r;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        we    = 1'b1;
        waddr = cur_r;
        if (life_q_r <= step_r) begin
          wdata    = '0;
          tail_nxt = wrap_inc(tail_r);
          exp_nxt  = exp_r + 1'b1;
        end else begin
          wdata = life_q_r - step_r;
        end
        if (idx_inc == head_r) begin
          empty_nxt = (tail_nxt == head_r);
          state_nxt = ST_HOLD;
        end else begin
          cur_nxt = idx_inc;
          rd_addr = idx_inc;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result from the state as it stands after this cycle
  always_comb begin
    if (head_nxt >= tail_nxt) span = head_nxt - tail_nxt;
    else span = IW'({1'b0, head_nxt} + (IW + 1)'(DEPTH) - {1'b0, tail_nxt});
    live_w = empty_nxt ? '0 : CW'(span);
    exp_w  = CW'(exp_nxt);
    rsp.live_count    = (live_w > CW'(COUNT_MAX)) ? COUNT_MAX : live_w[5:0];
    rsp.is_empty      = empty_nxt;
    rsp.expired_count = (exp_w > CW'(COUNT_MAX)) ? COUNT_MAX : exp_w[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      exp_r       <= '0;
      cur_r       <= '0;
      max_life_r  <= MAX_LIFE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      exp_r   <= exp_nxt;
      cur_r   <= cur_nxt;
      if (cfg_valid && cfg_ready) max_life_r <= cfg_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    if (load_out) out_data_r <= rsp;
  end

  always_ff @(posedge clk) begin
    if (we) life_mem[waddr] <= wdata;
    life_q_r <= life_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[head_r] <= {in_data.pos_y, in_data.pos_x};
  end

endmodule

// ===== design/tarb_checker.sv =====
// Port-level checks for the TTL aging ring buffer, bound to the top level.
// Depends on tarb_pkg and ttl_aging_ring_buffer_defines.svh.
`include "ttl_aging_ring_buffer_defines.svh"

module tarb_checker
  import tarb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input in_req_t     in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_rsp_t    out_data,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `TARB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  `TARB_ASSERT_SAME(a_empty_cnt, out_valid, out_data.is_empty == (out_data.live_count == 6'd0), "empty flag disagrees with live count")

  `TARB_ASSERT_NEXT(a_add_rsp, in_valid && !in_stall && (in_data.func == FUNC_ADD), out_valid && (out_data.expired_count == 6'd0) && !out_data.is_empty, "add request result wrong")

  `TARB_ASSERT_NEXT(a_cfg_rdy, cfg_valid, cfg_ready, "config write refused")

endmodule

bind ttl_aging_ring_buffer tarb_checker u_tarb_checker (.*);
